/* sv/deadline_timeout_queue_core_assert.svh */
// Assertion macros for the deadline timeout queue core
`ifndef DEADLINE_TIMEOUT_QUEUE_CORE_ASSERT_SVH
`define DEADLINE_TIMEOUT_QUEUE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define DTQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked out of reset
`define DTQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DTQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define DTQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* sv/dtq_pkg.sv */
// Shared types and codes for the deadline timeout queue
`timescale 1ns / 1ps
package dtq_pkg;

  localparam int DTQ_DEPTH   = 16;
  localparam int DTQ_ID_BITS = 16;

  localparam int OP_W   = 2;
  localparam int ID_W   = 16;
  localparam int US_W   = 32;
  localparam int TIME_W = 64;
  localparam int STAT_W = 2;

  localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEL  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

  localparam logic KIND_EXPIRED = 1'b0;
  localparam logic KIND_DONE    = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;
    logic calc;
    logic apply;
    logic emit_exp;
    logic emit_done;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic head_expired;
  } stat_t;

endpackage

/* sv/deadline_timeout_queue_core.sv */
// Each item: busy through the calc, apply and check states; check repeats per expiring entry.
// Results: one expired item per cycle, registered from the check state, then done.
// Next item can be accepted in the cycle the done result shows.
// Rate is set by the sequencer and the one-pop-per-cycle head drain.
// Synchronous active-low reset empties the list and zeroes the time counter.
// Entry cells are not cleared; only cells below the count are ever read.
`timescale 1ns / 1ps
module deadline_timeout_queue_core #(
  parameter int DEPTH   = dtq_pkg::DTQ_DEPTH,
  parameter int ID_BITS = dtq_pkg::DTQ_ID_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [dtq_pkg::OP_W-1:0]    in_operation,
  input  logic [dtq_pkg::ID_W-1:0]    in_thread_id,
  input  logic [dtq_pkg::US_W-1:0]    in_microseconds,
  output logic                        out_strobe,
  output logic                        out_kind,
  output logic [dtq_pkg::ID_W-1:0]    out_expired_id,
  output logic [dtq_pkg::STAT_W-1:0]  out_status,
  output logic                        out_last
);
  import dtq_pkg::*;

  `include "deadline_timeout_queue_core_assert.svh"

  cmd_t  cmd;
  stat_t stat;

  // Sequencer
  dtq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // List, time and results
  dtq_datapath #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_operation    (in_operation),
    .in_thread_id    (in_thread_id),
    .in_microseconds (in_microseconds),
    .out_strobe      (out_strobe),
    .out_kind        (out_kind),
    .out_expired_id  (out_expired_id),
    .out_status      (out_status),
    .out_last        (out_last)
  );

  // Checks on sequencing and result framing
  `DTQ_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted item did not start work")
  `DTQ_ASSERT_IMP(a_exp_in_flight, clk, rst_n, out_strobe && (out_kind == KIND_EXPIRED), busy && !out_last, "expired item outside an item")
  `DTQ_ASSERT_NXT(a_done_frame, clk, rst_n, cmd.emit_done, !busy && out_strobe && out_last, "done item not framed")
  `DTQ_ASSERT_NXT(a_done_quiet, clk, rst_n, out_strobe && out_last, !out_strobe, "result right after done")

endmodule

/* sv/dtq_ctrl.sv */
// Controller state machine for the deadline timeout queue
`timescale 1ns / 1ps
module dtq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  dtq_pkg::stat_t stat,
  output dtq_pkg::cmd_t  cmd,
  output logic          busy
);
  import dtq_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CALC  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_CHECK = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Sequence one item: latch, add times, update list, drain expired heads
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.head_expired) begin
          cmd.emit_exp = 1'b1;
        end else begin
          cmd.emit_done = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/dtq_datapath.sv */
// Sorted entry list, time counter and result registers
`timescale 1ns / 1ps
module dtq_datapath #(
  parameter int DEPTH   = dtq_pkg::DTQ_DEPTH,
  parameter int ID_BITS = dtq_pkg::DTQ_ID_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dtq_pkg::cmd_t               cmd,
  output dtq_pkg::stat_t              stat,
  input  logic [dtq_pkg::OP_W-1:0]    in_operation,
  input  logic [dtq_pkg::ID_W-1:0]    in_thread_id,
  input  logic [dtq_pkg::US_W-1:0]    in_microseconds,
  output logic                        out_strobe,
  output logic                        out_kind,
  output logic [dtq_pkg::ID_W-1:0]    out_expired_id,
  output logic [dtq_pkg::STAT_W-1:0]  out_status,
  output logic                        out_last
);
  import dtq_pkg::*;

  localparam int IdW  = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int CntW = $clog2(DEPTH + 1);

  // Item registers
  logic [OP_W-1:0]   op_r;
  logic [IdW-1:0]    id_r;
  logic [US_W-1:0]   us_r;
  logic [TIME_W-1:0] dl_r;
  logic [TIME_W-1:0] time_r;
  logic [STAT_W-1:0] status_r;
  logic [STAT_W-1:0] status_nxt;

  // Entry cells, kept sorted by deadline from the head
  logic [IdW-1:0]    ids_r   [DEPTH];
  logic [TIME_W-1:0] dls_r   [DEPTH];
  logic [IdW-1:0]    ids_nxt [DEPTH];
  logic [TIME_W-1:0] dls_nxt [DEPTH];
  logic [CntW-1:0]   cnt_r;
  logic [CntW-1:0]   cnt_nxt;

  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] ins_b;
  logic [DEPTH-1:0] ins_prev;
  logic [DEPTH-1:0] del_m;
  logic [DEPTH-1:0] del_p;
  logic             found;
  logic             full;
  logic             seen;
  logic [TIME_W-1:0] sum;

  assign full = (cnt_r == CntW'(DEPTH));
  assign sum  = time_r + {{(TIME_W-US_W){1'b0}}, us_r};

  // Per-cell compare: occupancy, insert boundary and id match
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid[i] = (CntW'(i) < cnt_r);
      ins_b[i] = !valid[i] || (dl_r < dls_r[i]);
      del_m[i] = valid[i] && (ids_r[i] == id_r);
    end
  end

  assign ins_prev = {ins_b[DEPTH-2:0], 1'b0};

  // Mark cells at or past the first matching id
  always_comb begin
    seen = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      seen     = seen | del_m[i];
      del_p[i] = seen;
    end
  end

  assign found = del_p[DEPTH-1];

  // Next list contents: insert, delete or pop the head
  always_comb begin
    ids_nxt    = ids_r;
    dls_nxt    = dls_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    if (cmd.apply) begin
      status_nxt = ST_OK;
      unique case (op_r)
        OP_ADD: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              if (ins_b[i] && !ins_prev[i]) begin
                ids_nxt[i] = id_r;
                dls_nxt[i] = dl_r;
              end
            end
            // Shift cells past the insert point down by one
            for (int i = 1; i < DEPTH; i++) begin
              if (ins_prev[i]) begin
                ids_nxt[i] = ids_r[i-1];
                dls_nxt[i] = dls_r[i-1];
              end
            end
            cnt_nxt = cnt_r + CntW'(1);
          end
        end
        OP_DEL: begin
          if (found) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
              if (del_p[i]) begin
                ids_nxt[i] = ids_r[i+1];
                dls_nxt[i] = dls_r[i+1];
              end
            end
            cnt_nxt = cnt_r - CntW'(1);
          end else begin
            status_nxt = ST_NOT_FOUND;
          end
        end
        default: ;
      endcase
    end else if (cmd.emit_exp) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        ids_nxt[i] = ids_r[i+1];
        dls_nxt[i] = dls_r[i+1];
      end
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  assign stat.head_expired = (cnt_r != '0) && (dls_r[0] <= time_r);

  // Entry cells and item payload
  always_ff @(posedge clk) begin
    ids_r    <= ids_nxt;
    dls_r    <= dls_nxt;
    status_r <= status_nxt;
    if (cmd.latch) begin
      op_r <= in_operation;
      id_r <= in_thread_id[IdW-1:0];
      us_r <= in_microseconds;
    end
    if (cmd.calc) begin
      dl_r <= sum;
    end
  end

  // Count and time counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      time_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.calc && (op_r == OP_TICK)) begin
        time_r <= sum;
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= cmd.emit_exp | cmd.emit_done;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.emit_exp) begin
      out_kind       <= KIND_EXPIRED;
      out_expired_id <= ID_W'(ids_r[0]);
      out_status     <= ST_OK;
      out_last       <= 1'b0;
    end else if (cmd.emit_done) begin
      out_kind       <= KIND_DONE;
      out_expired_id <= '0;
      out_status     <= status_r;
      out_last       <= 1'b1;
    end
  end

endmodule
